@@ src/bit_chunk_to_word_packer_core_macros.svh @@
`ifndef BIT_CHUNK_TO_WORD_PACKER_CORE_MACROS_SVH
`define BIT_CHUNK_TO_WORD_PACKER_CORE_MACROS_SVH

// checked outside reset
`define BCWP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");

// checked in every cycle, reset included
`define BCWP_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m failed");

`endif

@@ src/bcwp_pkg.sv @@
package bcwp_pkg;

  localparam int CHUNK_W     = 8;
  localparam int PKT_W       = 8;
  localparam int NBITS_W     = 4;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;
  localparam int IDX_W       = 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [IDX_W-1:0] REG_CHUNK_BITS = 1'b0;
  localparam logic [IDX_W-1:0] REG_MSB_FIRST  = 1'b1;

  localparam logic [NBITS_W-1:0] CHUNK_BITS_RST = 4'd1;

  typedef struct packed {
    logic [NBITS_W-1:0] chunk_bits;
    logic               msb_first;
  } cfg_t;

  typedef struct packed {
    logic [CHUNK_W-1:0] data;
    logic [NBITS_W-1:0] nbits;
  } entry_t;

endpackage

@@ src/bcwp_ifs.sv @@
interface bcwp_chunk_if import bcwp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CHUNK_W-1:0] chunk;

  modport source (output valid, output chunk, input ready);
  modport sink (input valid, input chunk, output ready);
endinterface

interface bcwp_word_if import bcwp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PKT_W-1:0] packed_word;

  modport source (output valid, output packed_word, input ready);
  modport sink (input valid, input packed_word, output ready);
endinterface

@@ src/bcwp_cfg.sv @@
module bcwp_cfg import bcwp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic             wr;
  logic [IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chunk_bits <= CHUNK_BITS_RST;
      cfg.msb_first  <= 1'b1;
    end else if (wr) begin
      case (idx)
        REG_CHUNK_BITS: cfg.chunk_bits <= pwdata[NBITS_W-1:0];
        REG_MSB_FIRST:  cfg.msb_first  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CHUNK_BITS: prdata = DATA_W'(cfg.chunk_bits);
      REG_MSB_FIRST:  prdata = DATA_W'(cfg.msb_first);
      default:        prdata = '0;
    endcase
  end

endmodule

@@ src/bcwp_front.sv @@
module bcwp_front import bcwp_pkg::*; #(
  parameter int WORD_BITS = 8
) (
  input  cfg_t   cfg,
  input  logic   q_full,
  output logic   q_push,
  output entry_t q_entry,
  bcwp_chunk_if.sink chunks
);

  logic [NBITS_W-1:0]   nbits;
  logic [2*CHUNK_W-1:0] keep;

  always_comb begin
    if (cfg.chunk_bits == '0) begin
      nbits = NBITS_W'(1);
    end else if (32'(cfg.chunk_bits) > 32'(WORD_BITS)) begin
      nbits = NBITS_W'(WORD_BITS);
    end else begin
      nbits = cfg.chunk_bits;
    end
  end

  assign keep          = ((2*CHUNK_W)'(1) << nbits) - (2*CHUNK_W)'(1);
  assign chunks.ready  = !q_full;
  assign q_push        = chunks.valid && !q_full;
  assign q_entry.data  = chunks.chunk & keep[CHUNK_W-1:0];
  assign q_entry.nbits = nbits;

endmodule

@@ src/bcwp_fifo.sv @@
module bcwp_fifo import bcwp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wdata,
  input  logic   pop,
  output entry_t rdata,
  output logic   full,
  output logic   nonempty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [CNT_W-1:0]   count;

  assign full     = count == CNT_W'(QUEUE_DEPTH);
  assign nonempty = count != '0;
  assign rdata    = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (32'(wptr) == QUEUE_DEPTH - 1) ? '0 : wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= (32'(rptr) == QUEUE_DEPTH - 1) ? '0 : rptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ src/bcwp_back.sv @@
module bcwp_back import bcwp_pkg::*; #(
  parameter int WORD_BITS = 8
) (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   q_valid,
  input  entry_t q_data,
  output logic   q_pop,
  bcwp_word_if.source words
);

  localparam int CNT_W = $clog2(WORD_BITS);
  localparam int SUM_W = $clog2(2 * WORD_BITS);
  localparam int BIG_W = 2 * WORD_BITS;

  logic [WORD_BITS-1:0] pending;
  logic [WORD_BITS-1:0] pending_next;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [BIG_W-1:0]     joined;
  logic [BIG_W-1:0]     low_mask;
  logic [SUM_W-1:0]     total;
  logic [SUM_W-1:0]     excess;
  logic                 done;
  logic [WORD_BITS-1:0] word;
  logic [PKT_W-1:0]     word_rev;
  logic [PKT_W-1:0]     word_out;
  logic                 out_valid;
  logic [PKT_W-1:0]     out_word;

  always_comb begin
    joined   = ({{WORD_BITS{1'b0}}, pending} << q_data.nbits) | BIG_W'(q_data.data);
    total    = SUM_W'(count) + SUM_W'(q_data.nbits);
    done     = total >= SUM_W'(WORD_BITS);
    excess   = total - SUM_W'(WORD_BITS);
    low_mask = (BIG_W'(1) << excess) - BIG_W'(1);
    word     = WORD_BITS'(joined >> excess);
    if (done) begin
      pending_next = WORD_BITS'(joined & low_mask);
      count_next   = CNT_W'(excess);
    end else begin
      pending_next = WORD_BITS'(joined);
      count_next   = CNT_W'(total);
    end
    for (int i = 0; i < PKT_W; i++) begin
      word_rev[i] = word[WORD_BITS-1-i];
    end
    word_out = cfg.msb_first ? word[PKT_W-1:0] : word_rev;
  end

  assign q_pop             = q_valid && (!out_valid || words.ready);
  assign words.valid       = out_valid;
  assign words.packed_word = out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        pending <= pending_next;
        count   <= count_next;
      end
      if (q_pop && done) begin
        out_valid <= 1'b1;
      end else if (words.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && done) begin
      out_word <= word_out;
    end
  end

endmodule

@@ src/bit_chunk_to_word_packer_core.sv @@
// Path: a chunk that completes a word is written into the queue, then popped by the back end,
//   which registers words.valid and the packed word.
// Throughput: one chunk per cycle while the output is not stalled by words.ready,
//   set by the combinational back-end shift-and-merge; at most one packed word per chunk.
// Reset (rst, synchronous, active high): clears gathered bits, bit count, queue and output
//   valid; chunk_bits returns to 1 and msb_first to 1.
module bit_chunk_to_word_packer_core import bcwp_pkg::*; #(
  parameter int WORD_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  bcwp_chunk_if.sink        chunks,
  bcwp_word_if.source       words
);

  cfg_t   cfg;
  logic   q_full;
  logic   q_push;
  logic   q_pop;
  logic   q_nonempty;
  entry_t q_in;
  entry_t q_out;

  bcwp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bcwp_front #(.WORD_BITS(WORD_BITS)) u_front (
    .cfg     (cfg),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_in),
    .chunks  (chunks)
  );

  bcwp_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wdata    (q_in),
    .pop      (q_pop),
    .rdata    (q_out),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  bcwp_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_nonempty),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .words   (words)
  );

endmodule

@@ src/bcwp_checker.sv @@
`include "bit_chunk_to_word_packer_core_macros.svh"

module bcwp_checker import bcwp_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PKT_W-1:0] out_word
);

  `BCWP_ASSERT_RST(a_reset_idle, rst |=> (in_ready && !out_valid))
  `BCWP_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
  `BCWP_ASSERT(a_full_after_push, !in_ready |-> ($past(in_valid && in_ready) || $past(!in_ready)))

endmodule

bind bit_chunk_to_word_packer_core bcwp_checker u_bcwp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (chunks.valid),
  .in_ready  (chunks.ready),
  .out_valid (words.valid),
  .out_ready (words.ready),
  .out_word  (words.packed_word)
);

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb import bcwp_pkg::*; ();

  typedef enum logic [1:0] {RX_ALWAYS, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 6;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  bcwp_chunk_if chunk_ch ();
  bcwp_word_if  word_ch ();

  bit_chunk_to_word_packer_core dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .chunks  (chunk_ch),
    .words   (word_ch)
  );

  // packer shadow state
  cfg_t             shadow_cfg;
  logic [PKT_W-1:0] gathered_bits = '0;
  int               gathered_count = 0;
  logic [PKT_W-1:0] expected_words[$];

  int       mismatches = 0;
  int       burst_left = 0;
  bit       gaps_on = 1;
  int       hold_asked = 0;
  int       hold_taken = 0;
  int       hold_left = 0;
  int       mode_left = 0;
  int       rx_cyc = 0;
  rx_mode_t rx_mode = RX_ALWAYS;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // Appends the used bits of one chunk; returns 1 when a word completes.
  function automatic bit pack_chunk(input logic [CHUNK_W-1:0] data,
                                    output logic [PKT_W-1:0] word_out);
    int n;
    int pos;
    bit got;
    n = int'(shadow_cfg.chunk_bits);
    got = 1'b0;
    word_out = '0;
    if (n == 0) n = 1;
    if (n > PKT_W) n = PKT_W;
    for (int k = 0; k < n; k++) begin
      pos = n - 1 - k;
      gathered_bits = {gathered_bits[PKT_W-2:0], data[pos]};
      gathered_count++;
      if (gathered_count == PKT_W) begin
        for (int i = 0; i < PKT_W; i++) begin
          word_out[i] = shadow_cfg.msb_first ? gathered_bits[i] : gathered_bits[PKT_W-1-i];
        end
        got = 1'b1;
        gathered_bits = '0;
        gathered_count = 0;
      end
    end
    return got;
  endfunction

  always @(posedge clk) begin : chunk_monitor
    logic [PKT_W-1:0] w;
    if (!rst && chunk_ch.valid && chunk_ch.ready) begin
      if (pack_chunk(chunk_ch.chunk, w)) expected_words.push_back(w);
    end
  end

  always @(posedge clk) begin : word_checker
    logic [PKT_W-1:0] want_word;
    if (!rst && word_ch.valid && word_ch.ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected packed_word: expected none, actual %h",
                 $time, word_ch.packed_word);
        mismatches++;
      end else begin
        want_word = expected_words.pop_front();
        if (word_ch.packed_word !== want_word) begin
          $display("%0t: packed_word mismatch: expected %h, actual %h",
                   $time, want_word, word_ch.packed_word);
          mismatches++;
        end
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    rx_cyc++;
    if (mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    if (hold_taken != hold_asked) begin
      hold_taken = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      word_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS:   word_ch.ready <= 1'b1;
        RX_LIGHT:    word_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY:    word_ch.ready <= 1'($urandom_range(0, 1));
        RX_PERIODIC: word_ch.ready <= ((rx_cyc % 5) < 2);
        default:     word_ch.ready <= 1'b1;
      endcase
    end
  end

  task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_CHUNK_BITS) shadow_cfg.chunk_bits = val[NBITS_W-1:0];
    else if (idx == REG_MSB_FIRST) shadow_cfg.msb_first = val[0];
  endtask

  task automatic send_chunk(input logic [CHUNK_W-1:0] data);
    int gap;
    if (burst_left == 0) begin
      if (gaps_on) begin
        gap = $urandom_range(1, 6);
        chunk_ch.valid <= 1'b0;
        chunk_ch.chunk <= CHUNK_W'($urandom);
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    chunk_ch.valid <= 1'b1;
    chunk_ch.chunk <= data;
    @(posedge clk);
    while (!chunk_ch.ready) @(posedge clk);
  endtask

  // block idle: every word out and the pipe settled
  task automatic drain;
    chunk_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [NBITS_W-1:0] cb, input logic msb);
    drain();
    reg_write(REG_CHUNK_BITS, DATA_W'(cb));
    reg_write(REG_MSB_FIRST, DATA_W'(msb));
  endtask

  task automatic test_reset_defaults;
    // one bit per chunk, upper bits must be ignored
    send_chunk(8'hFF);
    send_chunk(8'h00);
    send_chunk(8'hFE);
    send_chunk(8'h01);
    send_chunk(8'h81);
    send_chunk(8'h7E);
    send_chunk(8'h01);
    send_chunk(8'h00);
  endtask

  task automatic test_directed;
    set_config(4'd8, 1'b1);
    send_chunk(8'h00);
    send_chunk(8'hFF);
    send_chunk(8'hA5);
    set_config(4'd8, 1'b0);
    send_chunk(8'h01);
    send_chunk(8'h80);
    // zero width reads as one bit
    set_config(4'd0, 1'b1);
    send_chunk(8'hFF);
    send_chunk(8'hFE);
    // oversize width saturates to a full chunk
    set_config(4'd15, 1'b1);
    send_chunk(8'hC3);
    send_chunk(8'h3C);
    set_config(4'd9, 1'b0);
    send_chunk(8'h96);
    // width change with bits pending
    set_config(4'd3, 1'b1);
    send_chunk(8'hFD);
    set_config(4'd5, 1'b1);
    send_chunk(8'h12);
    // order change with bits pending
    set_config(4'd4, 1'b1);
    send_chunk(8'h0B);
    set_config(4'd4, 1'b0);
    send_chunk(8'h07);
  endtask

  task automatic test_random;
    logic [NBITS_W-1:0] cb;
    logic               msb;
    for (int phase = 0; phase < 14; phase++) begin
      case (phase)
        0: begin cb = 4'd1;  msb = 1'b0; end
        1: begin cb = 4'd8;  msb = 1'b1; end
        2: begin cb = 4'd0;  msb = 1'b0; end
        3: begin cb = 4'd15; msb = 1'b1; end
        default: begin
          if ($urandom_range(0, 7) == 0)
            cb = $urandom_range(0, 1) ? NBITS_W'($urandom_range(9, 15)) : 4'd0;
          else
            cb = NBITS_W'($urandom_range(1, 8));
          msb = 1'($urandom_range(0, 1));
        end
      endcase
      set_config(cb, msb);
      gaps_on = ($urandom_range(0, 3) != 0);
      burst_left = 0;
      for (int i = 0; i < 55; i++) send_chunk(CHUNK_W'($urandom_range(0, 255)));
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_backpressure;
    set_config(4'd8, 1'b1);
    gaps_on = 1'b0;
    burst_left = 0;
    hold_asked++;
    for (int i = 0; i < 40; i++) send_chunk(CHUNK_W'($urandom));
    gaps_on = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    chunk_ch.valid = 1'b0;
    chunk_ch.chunk = '0;
    shadow_cfg.chunk_bits = 4'd1;
    shadow_cfg.msb_first = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_directed();
    test_random();
    test_backpressure();
    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
